/* rtl/srds_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srds_pkg
// Shared types and constants for the signed radix to digit string block.
// ----------------------------------------------------------------------------
package srds_pkg;

    // Field and register widths
    localparam int VALUE_W     = 32;
    localparam int CHAR_W      = 8;
    localparam int ALPHA_LEN   = 16;
    localparam int ALPHA_IDX_W = 4;
    localparam int BASE_W      = 5;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    // Digit stack and divider sizing
    localparam int MAX_DIGITS  = 32;
    localparam int SP_W        = $clog2(MAX_DIGITS);
    localparam int ND_W        = SP_W + 1;
    localparam int STEP_BITS   = 8;
    localparam int DIV_STEPS   = VALUE_W / STEP_BITS;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    // Register indexes
    typedef logic [CFG_IDX_W-1:0] srds_cfg_idx_t;
    localparam srds_cfg_idx_t CFG_ALPHA_LO  = 2'd0;
    localparam srds_cfg_idx_t CFG_ALPHA_HI  = 2'd1;
    localparam srds_cfg_idx_t CFG_BASE_SIZE = 2'd2;

    // Register reset values: alphabet "0123456789", radix ten
    localparam logic [CFG_W-1:0]  ALPHA_LO_RST = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0]  ALPHA_HI_RST = 64'h0000_0000_0000_3938;
    localparam logic [BASE_W-1:0] BASE_RST     = 5'd10;

    // Characters that may not appear in an alphabet
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

    // Source of the next output beat
    typedef enum logic [1:0] {
        OSEL_ERR,
        OSEL_ZERO,
        OSEL_SIGN,
        OSEL_DIG
    } srds_osel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       load_in;   // latch the input value, clear counters
        logic       chk_inc;   // advance the alphabet check index
        logic       div_step;  // one divider step
        logic       out_load;  // load the output register
        logic       pop;       // take the top digit off the stack
        srds_osel_t osel;
    } srds_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic size_bad;   // radix out of range
        logic char_bad;   // checked character reserved or repeated
        logic chk_last;   // checked character is the last in use
        logic mag_zero;   // magnitude is zero
        logic neg;        // input was negative
        logic step_last;  // divider is on the last step of a digit
        logic quo_zero;   // quotient of this digit is zero
        logic one_left;   // one digit left on the stack
        logic out_free;   // output register can take a beat
    } srds_status_t;

    function automatic logic is_reserved_char(input logic [CHAR_W-1:0] c);
        return (c == CHAR_NUL) || (c == CHAR_SPACE) || (c == CHAR_PLUS) ||
               (c == CHAR_MINUS);
    endfunction

endpackage
`default_nettype wire

/* rtl/srds_value_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srds_value_if
// Input channel: one signed integer per beat.
// ----------------------------------------------------------------------------
interface srds_value_if;
    logic                               valid;
    logic                               ready;
    logic signed [srds_pkg::VALUE_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface
`default_nettype wire

/* rtl/srds_char_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srds_char_if
// Output channel: one character per beat with end and error marks.
// ----------------------------------------------------------------------------
interface srds_char_if;
    logic                        valid;
    logic                        ready;
    logic [srds_pkg::CHAR_W-1:0] char_out;
    logic                        last;
    logic                        bad_base;

    modport source (output valid, output char_out, output last, output bad_base,
                    input ready);
    modport sink (input valid, input char_out, input last, input bad_base,
                  output ready);
endinterface
`default_nettype wire

/* rtl/srds_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srds_ctrl
// Sequencer: alphabet check, digit extraction, then character emission.
// ----------------------------------------------------------------------------
module srds_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire srds_pkg::srds_status_t st,
    output srds_pkg::srds_cmd_t         cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_CHECK = 7'b000_0010,
        S_ERR   = 7'b000_0100,
        S_ZERO  = 7'b000_1000,
        S_DIV   = 7'b001_0000,
        S_SIGN  = 7'b010_0000,
        S_DIGS  = 7'b100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.osel     = srds_pkg::OSEL_DIG;
        in_ready     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.size_bad || st.char_bad)
                    state_next = S_ERR;
                else if (st.chk_last)
                    state_next = st.mag_zero ? S_ZERO : S_DIV;
                else
                    cmd.chk_inc = 1'b1;
            end
            S_ERR:
            begin
                cmd.osel = srds_pkg::OSEL_ERR;
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_ZERO:
            begin
                cmd.osel = srds_pkg::OSEL_ZERO;
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.step_last && st.quo_zero)
                    state_next = st.neg ? S_SIGN : S_DIGS;
            end
            S_SIGN:
            begin
                cmd.osel = srds_pkg::OSEL_SIGN;
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_DIGS;
                end
            end
            S_DIGS:
            begin
                cmd.osel = srds_pkg::OSEL_DIG;
                if (st.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.pop      = 1'b1;
                    if (st.one_left)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* rtl/srds_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srds_dp
// Datapath: config registers, alphabet check, radix divider, digit stack,
// output register.
// ----------------------------------------------------------------------------
module srds_dp #(
    parameter int MAX_BASE = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [srds_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [srds_pkg::CFG_W-1:0]            cfg_data,
    input  wire logic signed [srds_pkg::VALUE_W-1:0]   value,
    input  wire srds_pkg::srds_cmd_t                   cmd,
    output srds_pkg::srds_status_t                     st,
    srds_char_if.source                                text_ch
);

    localparam int DIG_W = $clog2(MAX_BASE);
    localparam int QHI_W = srds_pkg::VALUE_W - srds_pkg::STEP_BITS;

    // Configuration
    logic [srds_pkg::CFG_W-1:0]  alpha_lo_reg;
    logic [srds_pkg::CFG_W-1:0]  alpha_hi_reg;
    logic [srds_pkg::BASE_W-1:0] base_size_reg;

    // Conversion state
    logic                              neg_reg;
    logic [srds_pkg::VALUE_W-1:0]      mag_reg;
    logic [QHI_W-1:0]                  quo_reg;
    logic [DIG_W-1:0]                  rem_reg;
    logic [srds_pkg::STEP_W-1:0]       step_reg;
    logic [DIG_W-1:0]                  chk_reg;
    logic [srds_pkg::ND_W-1:0]         nd_reg;
    logic [DIG_W-1:0]                  stack_reg [srds_pkg::MAX_DIGITS];

    // Output register
    logic                         out_valid_reg;
    logic [srds_pkg::CHAR_W-1:0]  out_char_reg;
    logic                         out_last_reg;
    logic                         out_bad_reg;

    // Combinational
    logic [srds_pkg::CHAR_W-1:0]    chars [srds_pkg::ALPHA_LEN];
    logic [srds_pkg::CHAR_W-1:0]    chk_char;
    logic                           dup;
    logic [srds_pkg::VALUE_W-1:0]   value_u;
    logic [srds_pkg::VALUE_W-1:0]   mag_in;
    logic [DIG_W:0]                 radix;
    logic [DIG_W:0]                 trial;
    logic [DIG_W-1:0]               rem_v;
    logic [srds_pkg::STEP_BITS-1:0] chunk;
    logic [srds_pkg::STEP_BITS-1:0] qbits;
    logic [srds_pkg::VALUE_W-1:0]   quo_full;
    logic [srds_pkg::ND_W-1:0]      nd_m1;
    logic [DIG_W-1:0]               top_digit;
    logic [srds_pkg::CHAR_W-1:0]    char_sel;
    logic                           last_sel;
    logic                           bad_sel;
    logic                           push;

    // Alphabet as a character array
    always_comb
    begin
        for (int i = 0; i < srds_pkg::ALPHA_LEN / 2; i++)
        begin
            chars[srds_pkg::ALPHA_IDX_W'(i)] =
                alpha_lo_reg[i*srds_pkg::CHAR_W +: srds_pkg::CHAR_W];
            chars[srds_pkg::ALPHA_IDX_W'(i + srds_pkg::ALPHA_LEN / 2)] =
                alpha_hi_reg[i*srds_pkg::CHAR_W +: srds_pkg::CHAR_W];
        end
    end

    // Check of one character against the reserved set and all later ones in use
    assign chk_char = chars[srds_pkg::ALPHA_IDX_W'(chk_reg)];

    always_comb
    begin
        dup = 1'b0;
        for (int b = 0; b < srds_pkg::ALPHA_LEN; b++)
        begin
            if ((srds_pkg::BASE_W'(b) > srds_pkg::BASE_W'(chk_reg)) &&
                (srds_pkg::BASE_W'(b) < base_size_reg) &&
                (chars[srds_pkg::ALPHA_IDX_W'(b)] == chk_char))
                dup = 1'b1;
        end
    end

    assign st.size_bad = (base_size_reg < srds_pkg::BASE_W'(2)) ||
                         (base_size_reg > srds_pkg::BASE_W'(MAX_BASE));
    assign st.char_bad = srds_pkg::is_reserved_char(chk_char) || dup;
    assign st.chk_last = (srds_pkg::BASE_W'(chk_reg) == (base_size_reg - 1'b1));

    // Magnitude of the input
    assign value_u = unsigned'(value);
    assign mag_in  = value_u[srds_pkg::VALUE_W-1] ? (~value_u + 1'b1) : value_u;

    // Divider: one byte of the dividend per cycle, restoring steps
    assign radix = base_size_reg[DIG_W:0];
    assign chunk = mag_reg[srds_pkg::VALUE_W-1 -: srds_pkg::STEP_BITS];

    always_comb
    begin
        rem_v = rem_reg;
        qbits = '0;
        trial = '0;
        for (int i = srds_pkg::STEP_BITS - 1; i >= 0; i--)
        begin
            trial = {rem_v, chunk[i]};
            if (trial >= radix)
            begin
                trial    = trial - radix;
                qbits[i] = 1'b1;
            end
            rem_v = trial[DIG_W-1:0];
        end
    end

    assign quo_full     = {quo_reg, qbits};
    assign st.step_last = (step_reg == srds_pkg::STEP_W'(srds_pkg::DIV_STEPS - 1));
    assign st.quo_zero  = (quo_full == '0);
    assign st.mag_zero  = (mag_reg == '0);
    assign st.neg       = neg_reg;
    assign push         = cmd.div_step && st.step_last;

    // Digit stack top
    assign nd_m1       = nd_reg - 1'b1;
    assign top_digit   = stack_reg[nd_m1[srds_pkg::SP_W-1:0]];
    assign st.one_left = (nd_reg == srds_pkg::ND_W'(1));
    assign st.out_free = !out_valid_reg || text_ch.ready;

    // Output beat select
    always_comb
    begin
        unique case (cmd.osel)
            srds_pkg::OSEL_ERR:
            begin
                char_sel = '0;
                last_sel = 1'b1;
                bad_sel  = 1'b1;
            end
            srds_pkg::OSEL_ZERO:
            begin
                char_sel = chars[0];
                last_sel = 1'b1;
                bad_sel  = 1'b0;
            end
            srds_pkg::OSEL_SIGN:
            begin
                char_sel = srds_pkg::CHAR_MINUS;
                last_sel = 1'b0;
                bad_sel  = 1'b0;
            end
            srds_pkg::OSEL_DIG:
            begin
                char_sel = chars[srds_pkg::ALPHA_IDX_W'(top_digit)];
                last_sel = st.one_left;
                bad_sel  = 1'b0;
            end
            default:
            begin
                char_sel = '0;
                last_sel = 1'b1;
                bad_sel  = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_lo_reg  <= srds_pkg::ALPHA_LO_RST;
            alpha_hi_reg  <= srds_pkg::ALPHA_HI_RST;
            base_size_reg <= srds_pkg::BASE_RST;
            step_reg      <= '0;
            chk_reg       <= '0;
            nd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    srds_pkg::CFG_ALPHA_LO:  alpha_lo_reg  <= cfg_data;
                    srds_pkg::CFG_ALPHA_HI:  alpha_hi_reg  <= cfg_data;
                    srds_pkg::CFG_BASE_SIZE: base_size_reg <= cfg_data[srds_pkg::BASE_W-1:0];
                    default: ;
                endcase
            end

            if (cmd.load_in)
            begin
                step_reg <= '0;
                chk_reg  <= '0;
                nd_reg   <= '0;
            end
            else
            begin
                if (cmd.chk_inc)
                    chk_reg <= chk_reg + 1'b1;
                if (cmd.div_step)
                    step_reg <= st.step_last ? '0 : step_reg + 1'b1;
                if (push)
                    nd_reg <= nd_reg + 1'b1;
                else if (cmd.pop)
                    nd_reg <= nd_m1;
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (text_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            neg_reg <= value_u[srds_pkg::VALUE_W-1];
            mag_reg <= mag_in;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (st.step_last)
            begin
                mag_reg <= quo_full;
                rem_reg <= '0;
                stack_reg[nd_reg[srds_pkg::SP_W-1:0]] <= rem_v;
            end
            else
            begin
                mag_reg <= mag_reg << srds_pkg::STEP_BITS;
                quo_reg <= quo_full[QHI_W-1:0];
                rem_reg <= rem_v;
            end
        end

        if (cmd.out_load)
        begin
            out_char_reg <= char_sel;
            out_last_reg <= last_sel;
            out_bad_reg  <= bad_sel;
        end
    end

    assign text_ch.valid    = out_valid_reg;
    assign text_ch.char_out = out_char_reg;
    assign text_ch.last     = out_last_reg;
    assign text_ch.bad_base = out_bad_reg;

endmodule
`default_nettype wire

/* rtl/signed_radix_to_digit_string_top.sv */
`default_nettype none
// The block takes a value, checks the alphabet one character at a time, extracts
//   the digits in the byte-wide divider, then sends one beat per cycle while the
//   sink is ready. It takes one value at a time: a new value is accepted only
//   once the last beat of the previous one is loaded.
// Reset (rst_n, async low) returns the alphabet to "0123456789", radix ten,
//   and empties the output register.
// ----------------------------------------------------------------------------
// signed_radix_to_digit_string_top
// Converts a signed 32-bit integer to text in a configurable radix alphabet.
// ----------------------------------------------------------------------------
module signed_radix_to_digit_string_top #(
    parameter int MAX_BASE = 16
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [srds_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [srds_pkg::CFG_W-1:0]       cfg_data,
    srds_value_if.sink                            num_ch,
    srds_char_if.source                           text_ch
);

    srds_pkg::srds_cmd_t    cmd;
    srds_pkg::srds_status_t st;
    logic                   in_ready;

    assign num_ch.ready = in_ready;

    // Sequencer
    srds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (num_ch.valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    // Datapath
    srds_dp #(
        .MAX_BASE (MAX_BASE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .value     (num_ch.value),
        .cmd       (cmd),
        .st        (st),
        .text_ch   (text_ch)
    );

    // Busy right after taking a value
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        num_ch.valid && num_ch.ready |=> !num_ch.ready)
        else $error("input taken while a conversion is starting");

    // A pending beat that does not end the conversion keeps the input closed
    a_busy_mid_string: assert property (@(posedge clk) disable iff (!rst_n)
        text_ch.valid && !text_ch.last |-> !num_ch.ready)
        else $error("input open in the middle of a string");

    // Error beat is a lone, final, zero beat
    a_error_beat: assert property (@(posedge clk) disable iff (!rst_n)
        text_ch.valid && text_ch.bad_base |-> text_ch.last && (text_ch.char_out == '0))
        else $error("malformed error beat");

endmodule
`default_nettype wire

/* tb/tb_signed_radix_to_digit_string_top.sv */
// ----------------------------------------------------------------------------
// tb_signed_radix_to_digit_string_top
// Drives signed integers into the radix-to-text converter and checks every
// character beat against a predictor of the alphabet check and the digit
// expansion. Runs through decimal, binary, hex, broken alphabets and random
// alphabets, with source gaps and sink stalls varied per register setting.
// ----------------------------------------------------------------------------
module tb_signed_radix_to_digit_string_top;
    timeunit 1ns;
    timeprecision 1ps;

    import srds_pkg::*;

    localparam int MAX_BASE      = 16;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    localparam int RANDOM_SETS   = 10;
    localparam int VALUES_PER_SET = 10;

    // Index past the last register; writes to it must be dropped
    localparam srds_cfg_idx_t CFG_UNUSED = 2'd3;

    // Lowercase hex alphabet "0123456789abcdef"
    localparam logic [63:0] HEX_LO = 64'h3736_3534_3332_3130;
    localparam logic [63:0] HEX_HI = 64'h6665_6463_6261_3938;

    // Expected character beats, predicted from the register copy
    class digit_text_scoreboard;
        typedef struct packed {
            logic [CHAR_W-1:0] ch;
            logic              last;
            logic              bad;
        } beat_t;

        beat_t             expected_beats[$];
        logic [CFG_W-1:0]  alpha_lo;
        logic [CFG_W-1:0]  alpha_hi;
        logic [BASE_W-1:0] radix;
        int                mismatches;
        int                beats_checked;
        int                values_noted;
        int                error_results;

        function new();
            alpha_lo = ALPHA_LO_RST;
            alpha_hi = ALPHA_HI_RST;
            radix    = BASE_RST;
        endfunction

        function void set_reg(srds_cfg_idx_t idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_ALPHA_LO:  alpha_lo = data;
                CFG_ALPHA_HI:  alpha_hi = data;
                CFG_BASE_SIZE: radix = data[BASE_W-1:0];
                default: ;
            endcase
        endfunction

        function logic [CHAR_W-1:0] digit_char(int unsigned idx);
            logic [3:0]       k;
            logic [CFG_W-1:0] word;
            k    = idx[3:0];
            word = k[3] ? alpha_hi : alpha_lo;
            return word[k[2:0]*8 +: 8];
        endfunction

        function int outstanding();
            return expected_beats.size();
        endfunction

        // Alphabet check, then sign and digits most significant first
        function void note_value(logic signed [VALUE_W-1:0] v);
            int unsigned       n;
            logic [CHAR_W-1:0] c;
            bit                ok;
            logic [VALUE_W-1:0] mag;
            int unsigned       digs[MAX_DIGITS];
            int                nd;
            values_noted++;
            n  = 32'(radix);
            ok = (n >= 2) && (n <= MAX_BASE);
            for (int a = 0; ok && a < n; a++)
            begin
                c = digit_char(a);
                if (c == CHAR_NUL || c == CHAR_SPACE || c == CHAR_PLUS || c == CHAR_MINUS)
                    ok = 0;
                for (int b = a + 1; b < n; b++)
                    if (digit_char(b) == c)
                        ok = 0;
            end
            if (!ok)
            begin
                expected_beats.push_back('{ch: CHAR_NUL, last: 1'b1, bad: 1'b1});
                return;
            end
            // 0 - v keeps the most negative value's magnitude in 32 bits
            mag = v[VALUE_W-1] ? (32'd0 - v) : v;
            if (mag == 0)
            begin
                expected_beats.push_back('{ch: digit_char(0), last: 1'b1, bad: 1'b0});
                return;
            end
            nd = 0;
            while (mag != 0)
            begin
                digs[nd] = mag % n;
                mag      = mag / n;
                nd++;
            end
            if (v[VALUE_W-1])
                expected_beats.push_back('{ch: CHAR_MINUS, last: 1'b0, bad: 1'b0});
            while (nd > 0)
            begin
                nd--;
                expected_beats.push_back('{ch: digit_char(digs[nd]), last: (nd == 0),
                                           bad: 1'b0});
            end
        endfunction

        function void check_beat(logic [CHAR_W-1:0] ch, logic last, logic bad);
            beat_t want;
            beats_checked++;
            if (bad === 1'b1)
                error_results++;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected beat: char %h last %b bad_base %b",
                             $realtime, ch, last, bad);
                return;
            end
            want = expected_beats.pop_front();
            if ({want.ch, want.last, want.bad} !== {ch, last, bad})
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] mismatch (char/last/bad_base): expected %h/%b/%b, got %h/%b/%b",
                             $realtime, want.ch, want.last, want.bad, ch, last, bad);
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    srds_cfg_idx_t        cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int unsigned          src_idle_pct;
    int unsigned          snk_stall_pct;
    int                   cycle_count;
    int                   settings_applied;

    srds_value_if num_ch();
    srds_char_if  text_ch();

    digit_text_scoreboard sb = new();

    signed_radix_to_digit_string_top #(
        .MAX_BASE (MAX_BASE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .num_ch    (num_ch),
        .text_ch   (text_ch)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Cycle budget
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats still expected",
                     cycle_count, sb.outstanding());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sink side: random stalls
    always @(negedge clk)
        text_ch.ready <= ($urandom_range(0, 99) >= snk_stall_pct);

    // Output monitor
    always @(posedge clk)
        if (rst_n && text_ch.valid && text_ch.ready)
            sb.check_beat(text_ch.char_out, text_ch.last, text_ch.bad_base);

    // One input beat, with random gaps ahead of it
    task automatic send_value(logic signed [VALUE_W-1:0] v);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            num_ch.valid <= 1'b0;
            @(negedge clk);
        end
        num_ch.valid <= 1'b1;
        num_ch.value <= v;
        @(posedge clk);
        while (!num_ch.ready)
            @(posedge clk);
        sb.note_value(v);
        @(negedge clk);
    endtask

    // Caller lowers cfg_we after the last write of a group
    task automatic write_reg(srds_cfg_idx_t idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.set_reg(idx, data);
        @(negedge clk);
    endtask

    // Wait for every expected beat, then let the block go quiet
    task automatic settle();
        num_ch.valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // New register setting; idle pattern rotates with each setting
    task automatic configure(logic [CFG_W-1:0] alo, logic [CFG_W-1:0] ahi,
                             logic [CFG_W-1:0] size_word);
        settle();
        write_reg(CFG_ALPHA_LO, alo);
        write_reg(CFG_ALPHA_HI, ahi);
        write_reg(CFG_BASE_SIZE, size_word);
        cfg_we <= 1'b0;
        settings_applied++;
        case (settings_applied % 4)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 73; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 73; end
            default: begin src_idle_pct = 7; snk_stall_pct = 7; end
        endcase
    endtask

    initial
    begin
        logic [CHAR_W-1:0]         alpha_chars[ALPHA_LEN];
        logic [CHAR_W-1:0]         c;
        logic [CFG_W-1:0]          alo;
        logic [CFG_W-1:0]          ahi;
        logic [CFG_W-1:0]          size_word;
        logic signed [VALUE_W-1:0] v;
        int unsigned               n;
        int unsigned               j;
        bit                        clash;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_ALPHA_LO;
        cfg_data         = '0;
        num_ch.valid     = 1'b0;
        num_ch.value     = '0;
        text_ch.ready    = 1'b0;
        src_idle_pct     = 0;
        snk_stall_pct    = 0;
        cycle_count      = 0;
        settings_applied = 0;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset alphabet, decimal: zero, unit values, extremes
        send_value(32'sd0);
        send_value(32'sd1);
        send_value(-32'sd1);
        send_value(32'sh7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'sd10);
        send_value(-32'sd9);
        send_value(32'h5A5A_A5A5);

        // Binary, junk beyond the two digits in use: longest outputs
        alo = {$urandom, $urandom};
        alo[15:0] = 16'h3130;
        size_word = {$urandom, $urandom};
        size_word[BASE_W-1:0] = 5'd2;
        configure(alo, {$urandom, $urandom}, size_word);
        send_value(32'h8000_0000);
        send_value(32'sh7FFF_FFFF);

        // Full sixteen-character alphabet
        configure(HEX_LO, HEX_HI, 64'd16);
        send_value(-32'sd1);
        send_value(32'h8000_0000);
        send_value(32'sd0);

        // Radix out of range on both sides
        configure(HEX_LO, HEX_HI, 64'hFFFF_FFFF_FFFF_FFE0);
        send_value(32'sd77);
        configure(HEX_LO, HEX_HI, 64'd1);
        send_value(-32'sd77);
        configure(HEX_LO, HEX_HI, 64'd17);
        send_value(32'sd12345);
        configure(HEX_LO, HEX_HI, 64'hFFFF_FFFF_FFFF_FFFF);
        send_value(32'sd0);

        // Reserved characters and a repeat, the last character included
        configure({HEX_LO[63:8], CHAR_NUL}, HEX_HI, 64'd16);
        send_value(32'sd100);
        configure({CHAR_SPACE, HEX_LO[55:0]}, HEX_HI, 64'd16);
        send_value(32'sd100);
        configure(HEX_LO, {HEX_HI[63:8], CHAR_PLUS}, 64'd16);
        send_value(32'sd100);
        configure(HEX_LO, {CHAR_MINUS, HEX_HI[55:0]}, 64'd16);
        send_value(32'sd100);
        configure(HEX_LO, {8'h30, HEX_HI[55:0]}, 64'd16);
        send_value(32'sd100);

        // Reserved characters past base_size are ignored; zero uses digit 0
        configure({CHAR_MINUS, CHAR_NUL, CHAR_SPACE, 40'h65_6463_6261},
                  64'h2D00_2B20_2D00_2B20, 64'd5);
        send_value(32'sd0);
        send_value(-32'sd123456);

        // Write to the unused index leaves the setting alone
        settle();
        write_reg(CFG_UNUSED, {$urandom, $urandom});
        cfg_we <= 1'b0;
        send_value(32'sd255);

        // Random alphabets, mostly well formed
        for (int s = 0; s < RANDOM_SETS; s++)
        begin
            if ($urandom_range(0, 99) < 85)
                n = $urandom_range(2, MAX_BASE);
            else if ($urandom_range(0, 1))
                n = $urandom_range(0, 1);
            else
                n = $urandom_range(MAX_BASE + 1, 31);
            for (int i = 0; i < ALPHA_LEN; i++)
            begin
                if (i < n)
                begin
                    do
                    begin
                        c = CHAR_W'($urandom_range(1, 255));
                        clash = (c == CHAR_SPACE) || (c == CHAR_PLUS) || (c == CHAR_MINUS);
                        for (int k = 0; k < i; k++)
                            if (alpha_chars[k] == c)
                                clash = 1;
                    end
                    while (clash);
                    alpha_chars[i] = c;
                end
                else
                    alpha_chars[i] = CHAR_W'($urandom);
            end
            // Break one in five alphabets: reserved char or a repeat
            if (n >= 2 && n <= MAX_BASE && $urandom_range(0, 4) == 0)
            begin
                j = $urandom_range(0, n - 1);
                case ($urandom_range(0, 4))
                    0: alpha_chars[j] = CHAR_NUL;
                    1: alpha_chars[j] = CHAR_SPACE;
                    2: alpha_chars[j] = CHAR_PLUS;
                    3: alpha_chars[j] = CHAR_MINUS;
                    default: alpha_chars[j] = alpha_chars[(j + 1) % n];
                endcase
            end
            for (int i = 0; i < 8; i++)
            begin
                alo[i*8 +: 8] = alpha_chars[i];
                ahi[i*8 +: 8] = alpha_chars[i + 8];
            end
            size_word = {$urandom, $urandom};
            size_word[BASE_W-1:0] = BASE_W'(n);
            configure(alo, ahi, size_word);

            for (int i = 0; i < VALUES_PER_SET; i++)
            begin
                case ($urandom_range(0, 4))
                    0: v = $urandom;
                    1:
                    begin
                        v = $urandom_range(0, 40);
                        if ($urandom_range(0, 1))
                            v = -v;
                    end
                    2:
                    begin
                        case ($urandom_range(0, 4))
                            0: v = 32'sd0;
                            1: v = 32'sh7FFF_FFFF;
                            2: v = 32'h8000_0000;
                            3: v = -32'sd1;
                            default: v = 32'sd1;
                        endcase
                    end
                    3:
                    begin
                        v = $urandom >> $urandom_range(0, 31);
                        if ($urandom_range(0, 1))
                            v = -v;
                    end
                    default: v = $urandom | 32'h8000_0000;
                endcase
                send_value(v);
            end
        end

        // Drain and report
        settle();
        repeat (TAIL_CYCLES) @(negedge clk);
        $display("Converted %0d values into %0d beats under %0d register settings",
                 sb.values_noted, sb.beats_checked, settings_applied);
        $display("Alphabet error results: %0d, mismatches: %0d",
                 sb.error_results, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/srds_pkg.sv
rtl/srds_value_if.sv
rtl/srds_char_if.sv
rtl/srds_ctrl.sv
rtl/srds_dp.sv
rtl/signed_radix_to_digit_string_top.sv
tb/tb_signed_radix_to_digit_string_top.sv
